/* sv/uctp_pkg.sv */
// Package for the USB connector thermal protection block.
// Holds the payload structs, request and status codes and register indexes.
// No dependencies.
package uctp_pkg;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [11:0] ntc_mv;
      logic [11:0] hiccup_mv;
      logic        adapter_out;
   } req_payload_type;

   typedef struct packed {
      logic [1:0] status;
      logic       mosfet_high;
      logic       fault_latched;
      logic       connector_normal;
      logic       read_request;
      logic       plugged_in;
   } rsp_payload_type;

   // request codes
   localparam logic [1:0] REQ_SAMPLE      = 2'd0;
   localparam logic [1:0] REQ_ADAPTER_IN  = 2'd1;
   localparam logic [1:0] REQ_ADAPTER_OUT = 2'd2;
   localparam logic [1:0] REQ_TICK        = 2'd3;

   // status codes
   localparam logic [1:0] ST_NONE           = 2'd0;
   localparam logic [1:0] ST_CHG_ON_CLOSED  = 2'd1;
   localparam logic [1:0] ST_CHG_OFF_OPEN   = 2'd2;
   localparam logic [1:0] ST_CHG_OFF_CLOSED = 2'd3;

   // register indexes
   localparam int          CSR_IDX_BITS = 3;
   localparam int          CSR_DATA_BITS = 16;
   localparam logic [2:0]  CSR_NTC_LOW      = 3'd0;
   localparam logic [2:0]  CSR_NTC_MID      = 3'd1;
   localparam logic [2:0]  CSR_NTC_HIGH     = 3'd2;
   localparam logic [2:0]  CSR_HICCUP_OPEN  = 3'd3;
   localparam logic [2:0]  CSR_NTC_PERIOD   = 3'd4;
   localparam logic [2:0]  CSR_HICCUP_CHECK = 3'd5;

   // register reset values
   localparam logic [11:0] NTC_LOW_RST      = 12'd2000;
   localparam logic [11:0] NTC_MID_RST      = 12'd1200;
   localparam logic [11:0] NTC_HIGH_RST     = 12'd900;
   localparam logic [11:0] HICCUP_OPEN_RST  = 12'd1000;
   localparam logic [15:0] NTC_PERIOD_RST   = 16'd1000;
   localparam logic [15:0] HICCUP_CHECK_RST = 16'd100;

   // hiccup line below this after the check means the cable is gone
   localparam logic [11:0] HICCUP_UNPLUG_MV = 12'd20;

endpackage

/* sv/usb_connector_thermal_protect_top.sv */
// USB connector thermal protection. Depends on uctp_pkg.
// The response is registered: a request passes the input register, then the result
// register. Throughput is one item per cycle while the response is not stalled; all
// band compares and timer updates fit between the two registers. A stalled response
// stalls the request side once the input fills.
// Synchronous active-high reset restores register defaults, clears state and valids.
module usb_connector_thermal_protect_top #(
   parameter int SKIP_SAMPLES = 6,
   parameter int TIMER_BITS   = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  uctp_pkg::req_payload_type           req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output uctp_pkg::rsp_payload_type           rsp_data,
   input  logic                                csr_wr_en,
   input  logic [uctp_pkg::CSR_IDX_BITS-1:0]   csr_index,
   input  logic [uctp_pkg::CSR_DATA_BITS-1:0]  csr_wr_data
);
   import uctp_pkg::*;

   // configuration
   logic [11:0] ntc_low_ff, ntc_mid_ff, ntc_high_ff, hiccup_open_ff;
   logic [15:0] ntc_period_ff, hiccup_check_ff;

   // pipeline
   logic            in_valid_ff;
   req_payload_type in_data_ff;
   logic            out_valid_ff;
   rsp_payload_type out_data_ff;
   logic            req_accept, advance;

   // controller state
   logic                  plugged_ff, plugged_in;
   logic                  fault_ff, fault_in;
   logic [1:0]            status_ff, status_in;
   logic                  mosfet_ff, mosfet_in;
   logic                  adc_started_ff, adc_started_in;
   logic [2:0]            skip_ff, skip_in;
   logic [TIMER_BITS-1:0] period_timer_ff, period_timer_in;
   logic                  period_run_ff, period_run_in;
   logic [TIMER_BITS-1:0] hiccup_timer_ff, hiccup_timer_in;
   logic                  hiccup_run_ff, hiccup_run_in;
   logic [11:0]           last_ntc_ff, last_ntc_in;
   logic [11:0]           last_hiccup_ff, last_hiccup_in;
   logic                  read_req;
   logic                  unplug_ok;
   logic [TIMER_BITS-1:0] period_load, hiccup_load;
   rsp_payload_type       result;

   assign advance    = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall  = in_valid_ff && !advance;
   assign req_accept = req_valid && !req_stall;
   assign rsp_valid  = out_valid_ff;
   assign rsp_data   = out_data_ff;

   assign period_load = TIMER_BITS'(ntc_period_ff);
   assign hiccup_load = TIMER_BITS'(hiccup_check_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         ntc_low_ff      <= NTC_LOW_RST;
         ntc_mid_ff      <= NTC_MID_RST;
         ntc_high_ff     <= NTC_HIGH_RST;
         hiccup_open_ff  <= HICCUP_OPEN_RST;
         ntc_period_ff   <= NTC_PERIOD_RST;
         hiccup_check_ff <= HICCUP_CHECK_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_NTC_LOW:      ntc_low_ff      <= csr_wr_data[11:0];
            CSR_NTC_MID:      ntc_mid_ff      <= csr_wr_data[11:0];
            CSR_NTC_HIGH:     ntc_high_ff     <= csr_wr_data[11:0];
            CSR_HICCUP_OPEN:  hiccup_open_ff  <= csr_wr_data[11:0];
            CSR_NTC_PERIOD:   ntc_period_ff   <= csr_wr_data;
            CSR_HICCUP_CHECK: hiccup_check_ff <= csr_wr_data;
            default: ;
         endcase
      end
   end

   // unplug check uses the last stored sample, not the item at hand
   assign unplug_ok = !fault_ff || (last_ntc_ff >= ntc_low_ff) ||
                      ((last_ntc_ff < ntc_low_ff) && (last_ntc_ff > ntc_mid_ff)) ||
                      (last_ntc_ff < ntc_high_ff);

   always_comb begin
      plugged_in      = plugged_ff;
      fault_in        = fault_ff;
      status_in       = status_ff;
      mosfet_in       = mosfet_ff;
      adc_started_in  = adc_started_ff;
      skip_in         = skip_ff;
      period_timer_in = period_timer_ff;
      period_run_in   = period_run_ff;
      hiccup_timer_in = hiccup_timer_ff;
      hiccup_run_in   = hiccup_run_ff;
      last_ntc_in     = last_ntc_ff;
      last_hiccup_in  = last_hiccup_ff;
      read_req        = 1'b0;

      case (in_data_ff.req_type)
         REQ_SAMPLE: begin
            last_ntc_in    = in_data_ff.ntc_mv;
            last_hiccup_in = in_data_ff.hiccup_mv;
            if (skip_ff != 3'd0) begin
               skip_in = skip_ff - 3'd1;
            end else begin
               if (in_data_ff.ntc_mv >= ntc_low_ff) begin
                  fault_in  = 1'b0;
                  status_in = ST_CHG_ON_CLOSED;
               end else if (in_data_ff.ntc_mv >= ntc_mid_ff) begin
                  if (in_data_ff.adapter_out && !hiccup_run_ff) begin
                     hiccup_run_in   = 1'b1;
                     hiccup_timer_in = hiccup_load;
                  end
                  status_in = fault_ff ? ST_CHG_OFF_OPEN : ST_CHG_ON_CLOSED;
               end else begin
                  fault_in = 1'b1;
                  if (in_data_ff.ntc_mv >= ntc_high_ff) begin
                     status_in = (in_data_ff.hiccup_mv >= hiccup_open_ff) ?
                                 ST_CHG_OFF_OPEN : ST_CHG_OFF_CLOSED;
                  end else begin
                     if (in_data_ff.adapter_out) fault_in = 1'b0;
                     status_in = ST_CHG_OFF_CLOSED;
                  end
               end
               if (status_in == ST_CHG_ON_CLOSED || status_in == ST_CHG_OFF_CLOSED) begin
                  mosfet_in = 1'b0;
               end else begin
                  mosfet_in       = 1'b1;
                  period_run_in   = plugged_ff;
                  period_timer_in = plugged_ff ? period_load : '0;
               end
            end
         end
         REQ_ADAPTER_IN: begin
            plugged_in = 1'b1;
            read_req   = 1'b1;
            if (!adc_started_ff) begin
               adc_started_in = 1'b1;
               skip_in        = 3'(SKIP_SAMPLES);
            end
            period_run_in   = 1'b1;
            period_timer_in = period_load;
         end
         REQ_ADAPTER_OUT: begin
            if (unplug_ok) begin
               hiccup_run_in   = 1'b1;
               hiccup_timer_in = hiccup_load;
            end
         end
         default: begin // tick
            if (period_run_ff) begin
               if (period_timer_ff[TIMER_BITS-1:1] == '0) begin
                  read_req = 1'b1;
                  if (!adc_started_ff) begin
                     adc_started_in = 1'b1;
                     skip_in        = 3'(SKIP_SAMPLES);
                  end
                  period_run_in   = plugged_ff;
                  period_timer_in = plugged_ff ? period_load : '0;
               end else begin
                  period_timer_in = period_timer_ff - 1'b1;
               end
            end
            if (hiccup_run_ff) begin
               if (hiccup_timer_ff[TIMER_BITS-1:1] == '0) begin
                  hiccup_run_in   = 1'b0;
                  hiccup_timer_in = '0;
                  if (unplug_ok && (last_hiccup_ff < HICCUP_UNPLUG_MV)) begin
                     plugged_in      = 1'b0;
                     period_run_in   = 1'b0;
                     period_timer_in = '0;
                     fault_in        = 1'b0;
                     mosfet_in       = 1'b0;
                     status_in       = ST_NONE;
                  end
               end else begin
                  hiccup_timer_in = hiccup_timer_ff - 1'b1;
               end
            end
         end
      endcase

      result.status           = status_in;
      result.mosfet_high      = mosfet_in;
      result.fault_latched    = fault_in;
      result.connector_normal = (status_in != ST_CHG_OFF_OPEN) &&
                                (status_in != ST_CHG_OFF_CLOSED) && !fault_in;
      result.read_request     = read_req;
      result.plugged_in       = plugged_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff     <= 1'b0;
         out_valid_ff    <= 1'b0;
         plugged_ff      <= 1'b0;
         fault_ff        <= 1'b0;
         status_ff       <= ST_NONE;
         mosfet_ff       <= 1'b0;
         adc_started_ff  <= 1'b0;
         skip_ff         <= 3'd0;
         period_timer_ff <= '0;
         period_run_ff   <= 1'b0;
         hiccup_timer_ff <= '0;
         hiccup_run_ff   <= 1'b0;
         last_ntc_ff     <= 12'd0;
         last_hiccup_ff  <= 12'd0;
      end else begin
         in_valid_ff  <= req_accept || (in_valid_ff && !advance);
         out_valid_ff <= advance || (out_valid_ff && rsp_stall);
         if (advance) begin
            plugged_ff      <= plugged_in;
            fault_ff        <= fault_in;
            status_ff       <= status_in;
            mosfet_ff       <= mosfet_in;
            adc_started_ff  <= adc_started_in;
            skip_ff         <= skip_in;
            period_timer_ff <= period_timer_in;
            period_run_ff   <= period_run_in;
            hiccup_timer_ff <= hiccup_timer_in;
            hiccup_run_ff   <= hiccup_run_in;
            last_ntc_ff     <= last_ntc_in;
            last_hiccup_ff  <= last_hiccup_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_accept) in_data_ff <= req_data;
      if (advance)    out_data_ff <= result;
   end

endmodule

/* tb/sv/uctp_checker.sv */
// Checker for the USB connector thermal protection block: watches the request,
// response and register ports, predicts each response and compares it.
// Depends on uctp_pkg.
module uctp_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_stall,
   input  uctp_pkg::req_payload_type           req_data,
   input  logic                                rsp_valid,
   input  logic                                rsp_stall,
   input  uctp_pkg::rsp_payload_type           rsp_data,
   input  logic                                csr_wr_en,
   input  logic [uctp_pkg::CSR_IDX_BITS-1:0]   csr_index,
   input  logic [uctp_pkg::CSR_DATA_BITS-1:0]  csr_wr_data,
   output int                                  pending,
   output int                                  fail_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import uctp_pkg::*;

   localparam logic [2:0] SKIP_LOAD = 3'd6;

   // register copies
   logic [11:0] cool_thr, warm_thr, hot_thr, open_level;
   logic [15:0] period_load, check_load;

   // controller state
   logic        plugged, latched, mosfet_open, adc_armed, read_flag;
   logic [1:0]  status_q;
   logic [2:0]  skip_left;
   logic [15:0] period_cnt, check_cnt;
   logic        period_on, check_on;
   logic [11:0] last_ntc_mv, last_hic_mv;

   rsp_payload_type expected_rsp[$];
   int              errors = 0;

   assign fail_count = errors;

   function automatic void ask_read();
      read_flag = 1'b1;
      if (!adc_armed) begin
         adc_armed = 1'b1;
         skip_left = SKIP_LOAD;
      end
   endfunction

   function automatic void restart_period();
      period_on  = plugged;
      period_cnt = plugged ? period_load : 16'd0;
   endfunction

   function automatic void arm_check();
      check_on  = 1'b1;
      check_cnt = check_load;
   endfunction

   // thresholds are taken literally, even when out of order
   function automatic logic unplug_allowed();
      return !latched || last_ntc_mv >= cool_thr ||
             (last_ntc_mv < cool_thr && last_ntc_mv > warm_thr) ||
             last_ntc_mv < hot_thr;
   endfunction

   function automatic rsp_payload_type protect_step(input req_payload_type r);
      rsp_payload_type o;
      read_flag = 1'b0;
      case (r.req_type)
         REQ_SAMPLE: begin
            last_ntc_mv = r.ntc_mv;
            last_hic_mv = r.hiccup_mv;
            if (skip_left != 0) begin
               skip_left--;
            end else begin
               if (r.ntc_mv >= cool_thr) begin
                  latched  = 1'b0;
                  status_q = ST_CHG_ON_CLOSED;
               end else if (r.ntc_mv >= warm_thr) begin
                  if (r.adapter_out && !check_on)
                     arm_check();
                  status_q = latched ? ST_CHG_OFF_OPEN : ST_CHG_ON_CLOSED;
               end else begin
                  latched = 1'b1;
                  if (r.ntc_mv >= hot_thr) begin
                     status_q = (r.hiccup_mv >= open_level) ? ST_CHG_OFF_OPEN
                                                            : ST_CHG_OFF_CLOSED;
                  end else begin
                     if (r.adapter_out)
                        latched = 1'b0;
                     status_q = ST_CHG_OFF_CLOSED;
                  end
               end
               if (status_q == ST_CHG_ON_CLOSED || status_q == ST_CHG_OFF_CLOSED) begin
                  mosfet_open = 1'b0;
               end else begin
                  mosfet_open = 1'b1;
                  restart_period();
               end
            end
         end
         REQ_ADAPTER_IN: begin
            plugged = 1'b1;
            ask_read();
            restart_period();
         end
         REQ_ADAPTER_OUT: begin
            if (unplug_allowed())
               arm_check();
         end
         default: begin
            // periodic read first; the hiccup check may then stop it
            if (period_on) begin
               if (period_cnt <= 16'd1) begin
                  period_on  = 1'b0;
                  period_cnt = '0;
                  ask_read();
                  restart_period();
               end else begin
                  period_cnt--;
               end
            end
            if (check_on) begin
               if (check_cnt <= 16'd1) begin
                  check_on  = 1'b0;
                  check_cnt = '0;
                  if (unplug_allowed() && last_hic_mv < HICCUP_UNPLUG_MV) begin
                     plugged     = 1'b0;
                     period_on   = 1'b0;
                     period_cnt  = '0;
                     latched     = 1'b0;
                     mosfet_open = 1'b0;
                     status_q    = ST_NONE;
                  end
               end else begin
                  check_cnt--;
               end
            end
         end
      endcase
      o.status           = status_q;
      o.mosfet_high      = mosfet_open;
      o.fault_latched    = latched;
      o.connector_normal = status_q != ST_CHG_OFF_OPEN && status_q != ST_CHG_OFF_CLOSED &&
                           !latched;
      o.read_request     = read_flag;
      o.plugged_in       = plugged;
      return o;
   endfunction

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin : monitor
      rsp_payload_type want;
      if (reset) begin
         cool_thr    = NTC_LOW_RST;
         warm_thr    = NTC_MID_RST;
         hot_thr     = NTC_HIGH_RST;
         open_level  = HICCUP_OPEN_RST;
         period_load = NTC_PERIOD_RST;
         check_load  = HICCUP_CHECK_RST;
         plugged     = 1'b0;
         latched     = 1'b0;
         mosfet_open = 1'b0;
         adc_armed   = 1'b0;
         read_flag   = 1'b0;
         status_q    = ST_NONE;
         skip_left   = '0;
         period_cnt  = '0;
         check_cnt   = '0;
         period_on   = 1'b0;
         check_on    = 1'b0;
         last_ntc_mv = '0;
         last_hic_mv = '0;
         expected_rsp.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_NTC_LOW:      cool_thr    = csr_wr_data[11:0];
               CSR_NTC_MID:      warm_thr    = csr_wr_data[11:0];
               CSR_NTC_HIGH:     hot_thr     = csr_wr_data[11:0];
               CSR_HICCUP_OPEN:  open_level  = csr_wr_data[11:0];
               CSR_NTC_PERIOD:   period_load = csr_wr_data;
               CSR_HICCUP_CHECK: check_load  = csr_wr_data;
               default: ;
            endcase
         end
         // response side first so a new request cannot match an early response
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsp.size() == 0) begin
               $error("response transfer with no expected result");
               errors++;
            end else begin
               want = expected_rsp.pop_front();
               check_field("status", int'(want.status), int'(rsp_data.status));
               check_field("mosfet_high", int'(want.mosfet_high),
                           int'(rsp_data.mosfet_high));
               check_field("fault_latched", int'(want.fault_latched),
                           int'(rsp_data.fault_latched));
               check_field("connector_normal", int'(want.connector_normal),
                           int'(rsp_data.connector_normal));
               check_field("read_request", int'(want.read_request),
                           int'(rsp_data.read_request));
               check_field("plugged_in", int'(want.plugged_in), int'(rsp_data.plugged_in));
            end
         end
         if (req_valid && !req_stall)
            expected_rsp.push_back(protect_step(req_data));
      end
      pending <= expected_rsp.size();
   end

endmodule

/* tb/sv/tb_usb_connector_thermal_protect_top.sv */
// Testbench top for usb_connector_thermal_protect_top: clock, reset, register
// phases, directed and random request stimulus, and the verdict.
// Depends on uctp_pkg and uctp_checker.
module tb_usb_connector_thermal_protect_top;
   timeunit 1ns;
   timeprecision 1ps;
   import uctp_pkg::*;

   localparam int PHASES      = 8;
   localparam int HOLD_CYCLES = 40;

   logic                     clock       = 1'b0;
   logic                     reset       = 1'b1;
   logic                     req_valid   = 1'b0;
   logic                     req_stall;
   req_payload_type          req_data    = '0;
   logic                     rsp_valid;
   logic                     rsp_stall   = 1'b0;
   rsp_payload_type          rsp_data;
   logic                     csr_wr_en   = 1'b0;
   logic [CSR_IDX_BITS-1:0]  csr_index   = '0;
   logic [CSR_DATA_BITS-1:0] csr_wr_data = '0;

   int pending;
   int fail_count;
   int send_pct = 0;
   int rcv_pct  = 0;
   int hold_seq = 0;
   int cfg_low, cfg_mid, cfg_high, cfg_open;

   usb_connector_thermal_protect_top u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   uctp_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .pending     (pending),
      .fail_count  (fail_count)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   initial begin
      #4ms;
      $display("TB_ERROR");
      $finish;
   end

   // response stall: random per cycle, plus a long hold-off on request
   initial begin : stall_drive
      int seen;
      seen = 0;
      forever begin
         @(posedge clock);
         if (hold_seq != seen) begin
            seen = hold_seq;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_stall <= ($urandom_range(99) < rcv_pct);
      end
   end

   function automatic req_payload_type mk_req(input logic [1:0] kind, input logic [11:0] ntc,
                                              input logic [11:0] hic, input logic adp);
      req_payload_type r;
      r.req_type    = kind;
      r.ntc_mv      = ntc;
      r.hiccup_mv   = hic;
      r.adapter_out = adp;
      return r;
   endfunction

   function automatic logic [11:0] near_mv(input int base);
      int v;
      v = base + $urandom_range(4) - 2;
      if (v < 0) v = 0;
      if (v > 4095) v = 4095;
      return v[11:0];
   endfunction

   function automatic req_payload_type random_req();
      int pick, ntc_base;
      logic [11:0] ntc, hic;
      logic [1:0] kind;
      pick = $urandom_range(99);
      if (pick < 45)      kind = REQ_SAMPLE;
      else if (pick < 80) kind = REQ_TICK;
      else if (pick < 90) kind = REQ_ADAPTER_IN;
      else                kind = REQ_ADAPTER_OUT;
      case ($urandom_range(5))
         0: ntc_base = $urandom_range(4095);
         1: ntc_base = $urandom_range(1) ? 4095 : 0;
         2: ntc_base = cfg_low;
         3: ntc_base = cfg_mid;
         default: ntc_base = cfg_high;
      endcase
      ntc = near_mv(ntc_base);
      // low hiccup readings are what let the check declare an unplug
      case ($urandom_range(4))
         0: hic = 12'($urandom_range(4095));
         1, 2: hic = 12'($urandom_range(30));
         3: hic = near_mv(cfg_open);
         default: hic = $urandom_range(1) ? 12'd4095 : 12'd0;
      endcase
      return mk_req(kind, ntc, hic, 1'($urandom_range(1)));
   endfunction

   task automatic send_item(input req_payload_type item);
      while ($urandom_range(99) < send_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] val);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= val;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   task automatic apply_settings(input logic [11:0] lo, input logic [11:0] mid,
                                 input logic [11:0] hi, input logic [11:0] hic_lvl,
                                 input logic [15:0] period, input logic [15:0] check);
      cfg_low  = int'(lo);
      cfg_mid  = int'(mid);
      cfg_high = int'(hi);
      cfg_open = int'(hic_lvl);
      write_reg(CSR_NTC_LOW, {4'd0, lo});
      write_reg(CSR_NTC_MID, {4'd0, mid});
      write_reg(CSR_NTC_HIGH, {4'd0, hi});
      write_reg(CSR_HICCUP_OPEN, {4'd0, hic_lvl});
      write_reg(CSR_NTC_PERIOD, period);
      write_reg(CSR_HICCUP_CHECK, check);
   endtask

   // drop valid, wait for every transfer to come back, then a few more cycles
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   initial begin : stimulus
      int hi_v, mid_v, lo_v, tmax, n_items;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part: short timers so both fire within a few ticks
      apply_settings(12'd2000, 12'd1200, 12'd900, 12'd1000, 16'd3, 16'd2);
      send_item(mk_req(REQ_SAMPLE, 12'd2500, 12'd500, 1'b0));   // sample with no request
      send_item(mk_req(REQ_TICK, 12'd0, 12'd0, 1'b0));
      send_item(mk_req(REQ_ADAPTER_OUT, 12'd0, 12'd0, 1'b0));
      send_item(mk_req(REQ_TICK, 12'd0, 12'd0, 1'b0));
      send_item(mk_req(REQ_TICK, 12'd0, 12'd0, 1'b0));         // check fires, no unplug
      send_item(mk_req(REQ_ADAPTER_IN, 12'd0, 12'd0, 1'b0));   // first read arms the skip
      for (int k = 0; k < 6; k++)
         send_item(mk_req(REQ_SAMPLE, k[0] ? 12'd4095 : 12'd0, k[1] ? 12'd4095 : 12'd0,
                          k[0]));
      send_item(mk_req(REQ_SAMPLE, 12'd4095, 12'd4095, 1'b0)); // cool
      send_item(mk_req(REQ_SAMPLE, 12'd1500, 12'd0, 1'b1));    // warm, arms check
      send_item(mk_req(REQ_SAMPLE, 12'd1000, 12'd1000, 1'b0)); // hot, open
      send_item(mk_req(REQ_SAMPLE, 12'd1000, 12'd999, 1'b0));  // hot, closed
      send_item(mk_req(REQ_SAMPLE, 12'd1500, 12'd10, 1'b0));   // warm with latch set
      send_item(mk_req(REQ_SAMPLE, 12'd899, 12'd10, 1'b1));    // hottest, adapter gone
      send_item(mk_req(REQ_SAMPLE, 12'd0, 12'd10, 1'b0));
      send_item(mk_req(REQ_ADAPTER_OUT, 12'd0, 12'd0, 1'b0));
      send_item(mk_req(REQ_TICK, 12'd0, 12'd0, 1'b0));
      send_item(mk_req(REQ_TICK, 12'd0, 12'd0, 1'b0));         // unplug
      send_item(mk_req(REQ_TICK, 12'd0, 12'd0, 1'b0));
      send_item(mk_req(REQ_ADAPTER_IN, 12'd0, 12'd0, 1'b0));
      repeat (3) send_item(mk_req(REQ_TICK, 12'd4095, 12'd4095, 1'b1));

      for (int ph = 0; ph < PHASES; ph++) begin
         drain();
         case (ph)
            0: apply_settings(12'd2000, 12'd1200, 12'd900, 12'd1000, 16'd6, 16'd4);
            1, 6: begin
               tmax  = (ph == 1) ? 8 : 12;
               hi_v  = $urandom_range(1500);
               mid_v = hi_v + $urandom_range(1200);
               lo_v  = mid_v + $urandom_range(1300);
               apply_settings(12'(lo_v), 12'(mid_v), 12'(hi_v), 12'($urandom_range(4095)),
                              16'($urandom_range(tmax, 1)), 16'($urandom_range(tmax, 1)));
            end
            2: apply_settings(12'd4095, 12'd4095, 12'd4095, 12'd4095, 16'hFFFF, 16'hFFFF);
            3: apply_settings(12'd0, 12'd0, 12'd0, 12'd0, 16'd1, 16'd1);
            // thresholds out of order, timers loaded with zero
            4: apply_settings(12'd500, 12'd3000, 12'd2000, 12'($urandom_range(4095)),
                              16'd0, 16'd0);
            5: apply_settings(12'($urandom_range(4095)), 12'($urandom_range(4095)),
                              12'($urandom_range(4095)), 12'($urandom_range(4095)),
                              16'($urandom_range(20, 1)), 16'($urandom_range(20, 1)));
            default: apply_settings(NTC_LOW_RST, NTC_MID_RST, NTC_HIGH_RST, HICCUP_OPEN_RST,
                                    16'd2, 16'd3);
         endcase
         case (ph % 4)
            0: begin send_pct = 0;  rcv_pct <= 0;  end
            1: begin send_pct = 59; rcv_pct <= 0;  end
            2: begin send_pct = 0;  rcv_pct <= 59; end
            default: begin send_pct = 8; rcv_pct <= 8; end
         endcase
         if (ph == 4)
            hold_seq <= hold_seq + 1;
         n_items = (ph == 2 || ph == 7) ? 100 : 150;
         repeat (n_items) send_item(random_req());
      end

      rcv_pct <= 0;
      drain();
      if (fail_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

/* sim.f */
sv/uctp_pkg.sv
sv/usb_connector_thermal_protect_top.sv
tb/sv/uctp_checker.sv
tb/sv/tb_usb_connector_thermal_protect_top.sv
